[rtl/core/linear_recurrence_scan_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear recurrence scan block
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LINEAR_RECURRENCE_SCAN_TOP_ASSERT_SVH
`define LINEAR_RECURRENCE_SCAN_TOP_ASSERT_SVH

// same-cycle implication
`define LRS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lrs_pkg.sv]
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types, constants and Q16.16 arithmetic helpers for the scan block.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int LANE_W    = 4;
  localparam int LANE_CODES = 2 ** LANE_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SHIFT_W   = PROD_W - FRAC_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic        [LANE_W-1:0] lane_t;

  // scan direction held in the mode register
  typedef enum logic {
    MODE_FWD = 1'b0,
    MODE_BWD = 1'b1
  } scan_mode_t;

  localparam data_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // saturating signed add
  function automatic data_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? Q_MIN : Q_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  // Q16.16 multiply: exact product, floor shift, saturate
  function automatic data_t qmul(input data_t a, input data_t b);
    logic signed [PROD_W-1:0]  p;
    logic signed [SHIFT_W-1:0] q;
    p = a * b;
    q = p[PROD_W-1:FRAC_W];
    // upper bits must all match the sign of the kept word
    if (q[SHIFT_W-1:DATA_W-1] != {(SHIFT_W-DATA_W+1){q[SHIFT_W-1]}}) begin
      return q[SHIFT_W-1] ? Q_MIN : Q_MAX;
    end
    return q[DATA_W-1:0];
  endfunction

endpackage

[rtl/core/linear_recurrence_scan_top.sv]
// ----------------------------------------------------------------------------
// linear_recurrence_scan_top
// Per-lane Q16.16 linear recurrence, forward state or backward gradients.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transaction per timestep element, naming a lane.
//   Output channel out_*: exactly one transaction per input transaction, in
//   order, carrying the echoed lane, the new state (or b-gradient) and the
//   a-gradient (zero in forward mode).
//   Config channel cfg_*: one write sets scan_mode (0 forward, 1 backward);
//   cfg_ready is always high; write only while the block is idle.
// Path: an accepted transaction passes the input register, then the result
//   register, before out_valid rises.
// Throughput: one transaction per cycle while out_stall stays low, also when
//   consecutive transactions hit the same lane; the carry loop (carry read,
//   one multiply, one add, carry write) closes through a write bypass.
// Storage: carries sit in a LANES-deep RAM; a per-lane valid bit makes every
//   lane read as zero after reset, so no clearing pass is needed.
// Reset: rst_n synchronous active low; pipeline empties, mode returns to
//   forward, all carries read as zero.
// Stall: a stalled result holds on out_*; one further transaction is taken
//   into the input stage, then in_stall rises until the output drains.
// ----------------------------------------------------------------------------
`include "linear_recurrence_scan_top_assert.svh"

module linear_recurrence_scan_top
  import lrs_pkg::*;
#(
  parameter int LANES = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  // configuration
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  logic  cfg_data,
  // input channel
  input  logic  in_valid,
  output logic  in_stall,
  input  lane_t in_lane,
  input  logic  in_first_in_scan,
  input  logic  in_step_zero,
  input  data_t in_coef_a,
  input  data_t in_value_x,
  input  data_t in_prev_state,
  // result channel
  output logic  out_valid,
  input  logic  out_stall,
  output lane_t out_lane,
  output data_t out_state_out,
  output data_t out_grad_coef
);

  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  scan_mode_t mode_r, mode_nxt;

  // input stage
  logic             s1_v_r, s1_v_nxt;
  lane_t            s1_lane_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_first_r;
  logic             s1_zero_r;
  data_t            s1_a_r;
  data_t            s1_x_r;
  data_t            s1_hp_r;

  // carry store and bypass
  logic [LANES-1:0] vld_r, vld_nxt;
  logic             byp_hit_r, byp_hit_nxt;
  data_t            byp_data_r;
  data_t            ram_rdata;
  data_t            carry_cur;
  logic [IDX_W-1:0] lane_tbl [LANE_CODES];
  logic [IDX_W-1:0] rd_idx;

  // result stage
  logic  out_valid_r, out_valid_nxt;
  lane_t out_lane_r;
  data_t out_state_r;
  data_t out_grad_r;

  // handshake
  logic  accept;
  logic  out_free;
  logic  s1_adv;
  logic  carry_we;
  data_t dp_state;
  data_t dp_grad;
  data_t dp_carry;

  // configuration register
  assign cfg_ready = 1'b1;
  assign mode_nxt  = (cfg_valid && cfg_ready) ? scan_mode_t'(cfg_data) : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FWD;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // lane code to carry index, folded at elaboration
  for (genvar k = 0; k < LANE_CODES; k++) begin : g_lane_map
    localparam int MAPPED = k % LANES;
    assign lane_tbl[k] = IDX_W'(MAPPED);
  end

  assign rd_idx = lane_tbl[in_lane];

  // flow control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign accept   = in_valid && !in_stall;
  assign carry_we = s1_adv;

  assign s1_v_nxt = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lane_r  <= in_lane;
      s1_idx_r   <= rd_idx;
      s1_first_r <= in_first_in_scan;
      s1_zero_r  <= in_step_zero;
      s1_a_r     <= in_coef_a;
      s1_x_r     <= in_value_x;
      s1_hp_r    <= in_prev_state;
    end
  end

  // carry RAM: read on accept, write when the input stage moves on
  lrs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LANES),
    .AW    (IDX_W)
  ) u_carry_ram (
    .clk   (clk),
    .we    (carry_we),
    .waddr (s1_idx_r),
    .wdata (dp_carry),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // bypass a carry written on the same edge as the read
  assign byp_hit_nxt = accept ? (carry_we && (rd_idx == s1_idx_r)) : byp_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= byp_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data_r <= dp_carry;
    end
  end

  // per-lane written flags, a lane never written reads as zero
  always_comb begin
    vld_nxt = vld_r;
    if (carry_we) begin
      vld_nxt[s1_idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // carry seen by the item in the input stage
  always_comb begin
    if (s1_first_r) begin
      carry_cur = '0;
    end else if (byp_hit_r) begin
      carry_cur = byp_data_r;
    end else if (vld_r[s1_idx_r]) begin
      carry_cur = ram_rdata;
    end else begin
      carry_cur = '0;
    end
  end

  lrs_datapath u_datapath (
    .mode       (mode_r),
    .step_zero  (s1_zero_r),
    .coef_a     (s1_a_r),
    .value_x    (s1_x_r),
    .prev_state (s1_hp_r),
    .carry_in   (carry_cur),
    .state_out  (dp_state),
    .grad_coef  (dp_grad),
    .carry_out  (dp_carry)
  );

  // result register
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_lane_r  <= s1_lane_r;
      out_state_r <= dp_state;
      out_grad_r  <= dp_grad;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lane      = out_lane_r;
  assign out_state_out = out_state_r;
  assign out_grad_coef = out_grad_r;

  // checks
  `LRS_ASSERT_NOW(a_stall_only_when_full, in_stall, s1_v_r && out_valid_r, "stall with room")
  `LRS_ASSERT_NEXT(a_adv_gives_result, s1_adv, out_valid_r, "advanced item lost")
  `LRS_ASSERT_NOW(a_bypass_after_write, byp_hit_r && $past(accept), $past(carry_we),
                  "bypass without carry write")

endmodule

[rtl/core/lrs_ram.sv]
// ----------------------------------------------------------------------------
// lrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/lrs_datapath.sv]
// ----------------------------------------------------------------------------
// lrs_datapath
// One recurrence step: forward h = a*carry + x, or backward gradient step.
// ----------------------------------------------------------------------------
module lrs_datapath
  import lrs_pkg::*;
(
  input  scan_mode_t mode,
  input  logic       step_zero,
  input  data_t      coef_a,
  input  data_t      value_x,
  input  data_t      prev_state,
  input  data_t      carry_in,
  output data_t      state_out,
  output data_t      grad_coef,
  output data_t      carry_out
);

  data_t sum_bwd;
  data_t mul_b;
  data_t prod_a;
  data_t prod_h;

  // backward sum s = x + carry
  assign sum_bwd = sat_add(value_x, carry_in);

  // shared decay multiplier: a*carry forward, a*s backward
  assign mul_b  = (mode == MODE_BWD) ? sum_bwd : carry_in;
  assign prod_a = qmul(coef_a, mul_b);

  // a-gradient multiplier s*h_prev
  assign prod_h = qmul(sum_bwd, prev_state);

  always_comb begin
    state_out = '0;
    grad_coef = '0;
    carry_out = '0;
    unique case (mode)
      MODE_FWD: begin
        state_out = sat_add(prod_a, value_x);
        carry_out = state_out;
      end
      MODE_BWD: begin
        state_out = sum_bwd;
        grad_coef = step_zero ? '0 : prod_h;
        carry_out = prod_a;
      end
      default: begin
        state_out = '0;
      end
    endcase
  end

endmodule
